// ===== src/jet_pkg.sv =====
package jet_pkg;

    // fixed-point format of z and c
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 32;
    localparam int INDEX_BITS = 12;
    localparam int COUNT_BITS = 8;
    localparam int CFG_BITS   = 32;

    // default image size
    localparam int IMAGE_WIDTH_DEF  = 4096;
    localparam int IMAGE_HEIGHT_DEF = 4096;

    // register reset values
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 8'd255;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SEED_REAL  = 2'd0,
        CFG_SEED_IMAG  = 2'd1,
        CFG_ITER_LIMIT = 2'd2
    } cfg_index_t;

    // mapped start point of one pixel
    typedef struct packed {
        logic signed [COORD_BITS-1:0] re;
        logic signed [COORD_BITS-1:0] im;
    } start_t;

endpackage

// ===== src/jet_front.sv =====
module jet_front #(
    parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [jet_pkg::INDEX_BITS-1:0]  pixel_col,
    input  logic [jet_pkg::INDEX_BITS-1:0]  pixel_row,
    output logic                            push_valid,
    input  logic                            push_ready,
    output jet_pkg::start_t                 push_data
);
    import jet_pkg::*;

    localparam longint LAST_COL = IMAGE_WIDTH - 1;
    localparam longint LAST_ROW = IMAGE_HEIGHT - 1;
    localparam longint STEP_COL = ((64'sd1 <<< 30) + LAST_COL / 2) / LAST_COL;
    localparam longint STEP_ROW = ((64'sd1 <<< 30) + LAST_ROW / 2) / LAST_ROW;
    localparam logic [INDEX_BITS-1:0] LAST_COL_IDX = INDEX_BITS'(LAST_COL);
    localparam logic [INDEX_BITS-1:0] LAST_ROW_IDX = INDEX_BITS'(LAST_ROW);
    localparam logic [30:0] STEP_COL_C = 31'(STEP_COL);
    localparam logic [30:0] STEP_ROW_C = 31'(STEP_ROW);
    localparam logic [COORD_BITS-1:0] TWO_FIXED = COORD_BITS'(64'd2 << FRAC_BITS);
    localparam int PROD_BITS = INDEX_BITS + 31;

    logic                  valid_reg;
    logic                  valid_next;
    start_t                data_reg;
    start_t                data_next;
    logic [INDEX_BITS-1:0] col_clamped;
    logic [INDEX_BITS-1:0] row_clamped;
    logic [PROD_BITS-1:0]  prod_col;
    logic [PROD_BITS-1:0]  prod_row;
    logic                  take;

    // accept when the stage is empty or its content moves on
    assign in_stall   = valid_reg && !push_ready;
    assign take       = in_valid && !in_stall;
    assign push_valid = valid_reg;
    assign push_data  = data_reg;

    // clamp and map onto [-2, 2]
    always_comb
    begin
        col_clamped = (pixel_col > LAST_COL_IDX) ? LAST_COL_IDX : pixel_col;
        row_clamped = (pixel_row > LAST_ROW_IDX) ? LAST_ROW_IDX : pixel_row;
        prod_col    = PROD_BITS'(col_clamped) * PROD_BITS'(STEP_COL_C);
        prod_row    = PROD_BITS'(row_clamped) * PROD_BITS'(STEP_ROW_C);
        data_next   = data_reg;
        if (take)
        begin
            data_next.re = $signed(prod_col[COORD_BITS-1:0] - TWO_FIXED);
            data_next.im = $signed(prod_row[COORD_BITS-1:0] - TWO_FIXED);
        end
    end

    // stage occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== src/jet_queue.sv =====
module jet_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  jet_pkg::start_t push_data,
    output logic            pop_valid,
    input  logic            pop,
    output jet_pkg::start_t pop_data
);
    import jet_pkg::*;

    localparam int DEPTH = 2;

    start_t      mem [DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== src/jet_engine.sv =====
module jet_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pop_valid,
    output logic                                  pop,
    input  jet_pkg::start_t                       pop_data,
    input  logic signed [jet_pkg::COORD_BITS-1:0] seed_real,
    input  logic signed [jet_pkg::COORD_BITS-1:0] seed_imag,
    input  logic [jet_pkg::COUNT_BITS-1:0]        iteration_limit,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [jet_pkg::COUNT_BITS-1:0]        iteration_count
);
    import jet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    localparam int SQ_BITS  = 2 * COORD_BITS - FRAC_BITS;
    localparam int XY_BITS  = 2 * COORD_BITS - FRAC_BITS + 1;
    localparam int SUM_BITS = SQ_BITS + 1;
    localparam int NEW_BITS = XY_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] ESCAPE_LIMIT =
        SUM_BITS'(64'sd4 <<< FRAC_BITS);
    localparam logic signed [NEW_BITS-1:0] SAT_MAX = NEW_BITS'(64'sd2147483647);
    localparam logic signed [NEW_BITS-1:0] SAT_MIN = -NEW_BITS'(64'sd2147483648);
    localparam logic signed [COORD_BITS-1:0] Z_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_BITS-1:0] Z_MIN = 32'sh8000_0000;

    state_t                        state_reg;
    state_t                        state_next;
    logic signed [COORD_BITS-1:0]  zx_reg;
    logic signed [COORD_BITS-1:0]  zx_next;
    logic signed [COORD_BITS-1:0]  zy_reg;
    logic signed [COORD_BITS-1:0]  zy_next;
    logic signed [SQ_BITS-1:0]     xx_reg;
    logic signed [SQ_BITS-1:0]     xx_next;
    logic signed [SQ_BITS-1:0]     yy_reg;
    logic signed [SQ_BITS-1:0]     yy_next;
    logic signed [XY_BITS-1:0]     xy_reg;
    logic signed [XY_BITS-1:0]     xy_next;
    logic [COUNT_BITS-1:0]         it_reg;
    logic [COUNT_BITS-1:0]         it_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [COUNT_BITS-1:0]         count_reg;
    logic [COUNT_BITS-1:0]         count_next;
    logic signed [2*COORD_BITS-1:0] p_xx;
    logic signed [2*COORD_BITS-1:0] p_yy;
    logic signed [2*COORD_BITS-1:0] p_xy;
    logic signed [SUM_BITS-1:0]    mag;
    logic signed [NEW_BITS-1:0]    nx_wide;
    logic signed [NEW_BITS-1:0]    ny_wide;

    assign pop             = (state_reg == ST_IDLE) && pop_valid;
    assign out_valid       = out_valid_reg;
    assign iteration_count = count_reg;

    // squares and cross product, floored by dropping low bits
    always_comb
    begin
        p_xx    = 64'(zx_reg) * 64'(zx_reg);
        p_yy    = 64'(zy_reg) * 64'(zy_reg);
        p_xy    = 64'(zx_reg) * 64'(zy_reg);
        mag     = SUM_BITS'(xx_reg) + SUM_BITS'(yy_reg);
        nx_wide = NEW_BITS'(xx_reg) - NEW_BITS'(yy_reg) + NEW_BITS'(seed_real);
        ny_wide = NEW_BITS'(xy_reg) + NEW_BITS'(seed_imag);
    end

    // iteration sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        it_next        = it_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    zx_next    = pop_data.re;
                    zy_next    = pop_data.im;
                    it_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (it_reg >= iteration_limit)
                    state_next = ST_DONE;
                else
                begin
                    xx_next    = p_xx[2*COORD_BITS-1:FRAC_BITS];
                    yy_next    = p_yy[2*COORD_BITS-1:FRAC_BITS];
                    xy_next    = p_xy[2*COORD_BITS-1:FRAC_BITS-1];
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (mag >= ESCAPE_LIMIT)
                    state_next = ST_DONE;
                else
                begin
                    if (nx_wide > SAT_MAX)
                        zx_next = Z_MAX;
                    else if (nx_wide < SAT_MIN)
                        zx_next = Z_MIN;
                    else
                        zx_next = nx_wide[COORD_BITS-1:0];
                    if (ny_wide > SAT_MAX)
                        zy_next = Z_MAX;
                    else if (ny_wide < SAT_MIN)
                        zy_next = Z_MIN;
                    else
                        zy_next = ny_wide[COORD_BITS-1:0];
                    it_next    = it_reg + COUNT_BITS'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    count_next     = it_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        xy_reg    <= xy_next;
        it_reg    <= it_next;
        count_reg <= count_next;
    end

endmodule

// ===== src/julia_escape_time_pixel.sv =====
// Julia-set escape-time engine, one iteration count per pixel.
// Input channel: pixel_col / pixel_row with in_valid, in_stall; a transfer
// happens when in_valid is high and in_stall low. Output channel:
// iteration_count with out_valid, out_stall, same rule.
// Configuration: cfg_write_en with cfg_index (0 seed_real, 1 seed_imag,
// 2 iteration_limit) and cfg_data; write only while no pixel is in flight.
// The front stage clamps the indexes and maps them onto [-2, 2] in Q4.28,
// a two-entry queue decouples it from the iterating engine.
// Each iteration runs through the engine states ST_MUL, for the three 32x32
// products, and ST_UPD, for the escape compare and the saturating update.
// The front and queue keep taking pixels, until both are full, while the
// engine works or while a finished count waits on out_stall; a held result
// blocks only the next completion. Reset empties the queue and engine, sets
// the seed to 0 and the limit to 255.
module julia_escape_time_pixel #(
    parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [jet_pkg::INDEX_BITS-1:0] pixel_col,
    input  logic [jet_pkg::INDEX_BITS-1:0] pixel_row,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [jet_pkg::COUNT_BITS-1:0] iteration_count,
    input  logic                           cfg_write_en,
    input  logic [1:0]                     cfg_index,
    input  logic [jet_pkg::CFG_BITS-1:0]   cfg_data
);
    import jet_pkg::*;

    logic signed [COORD_BITS-1:0] seed_real_reg;
    logic signed [COORD_BITS-1:0] seed_imag_reg;
    logic [COUNT_BITS-1:0]        limit_reg;
    logic                         push_valid;
    logic                         push_ready;
    start_t                       push_data;
    logic                         pop_valid;
    logic                         pop;
    start_t                       pop_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_real_reg <= '0;
            seed_imag_reg <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SEED_REAL:  seed_real_reg <= $signed(cfg_data[COORD_BITS-1:0]);
                CFG_SEED_IMAG:  seed_imag_reg <= $signed(cfg_data[COORD_BITS-1:0]);
                CFG_ITER_LIMIT: limit_reg     <= cfg_data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // index mapping front stage
    jet_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // start point queue
    jet_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // iterating engine
    jet_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop             (pop),
        .pop_data        (pop_data),
        .seed_real       (seed_real_reg),
        .seed_imag       (seed_imag_reg),
        .iteration_limit (limit_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count)
    );

endmodule

// ===== bench/escape_time_checker.sv =====
module escape_time_checker #(
    parameter int IMAGE_WIDTH  = jet_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = jet_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [jet_pkg::INDEX_BITS-1:0] pixel_col,
    input  logic [jet_pkg::INDEX_BITS-1:0] pixel_row,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [jet_pkg::COUNT_BITS-1:0] iteration_count,
    input  logic                           cfg_write_en,
    input  logic [1:0]                     cfg_index,
    input  logic [jet_pkg::CFG_BITS-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             checked
);

    localparam int     FB        = jet_pkg::FRAC_BITS;
    localparam longint ESCAPE_SQ = 64'sd4 <<< FB;
    localparam longint TWO_Q     = 64'sd2 <<< FB;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;

    // one pixel and the count it should produce
    typedef struct {
        logic [jet_pkg::INDEX_BITS-1:0] col;
        logic [jet_pkg::INDEX_BITS-1:0] row;
        logic [jet_pkg::COUNT_BITS-1:0] count;
    } pixel_count_t;

    pixel_count_t count_q[$];

    // shadow copy of the seed and limit registers
    logic signed [jet_pkg::COORD_BITS-1:0] seed_re;
    logic signed [jet_pkg::COORD_BITS-1:0] seed_im;
    logic [jet_pkg::COUNT_BITS-1:0]        iter_max;

    // index -> Q4.28 start value, clamped at the last index
    function automatic longint start_coord(logic [jet_pkg::INDEX_BITS-1:0] idx, int size);
        longint last;
        longint step;
        longint k;
        last = size - 1;
        step = ((64'sd1 <<< 30) + last / 2) / last;
        k = (idx > last) ? last : longint'(idx);
        return k * step - TWO_Q;
    endfunction

    // saturate to the Q4.28 range
    function automatic longint clip_q(longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // iterate z = z*z + c until |z|^2 >= 4 or the limit
    function automatic logic [jet_pkg::COUNT_BITS-1:0] escape_count(
        logic [jet_pkg::INDEX_BITS-1:0] col,
        logic [jet_pkg::INDEX_BITS-1:0] row
    );
        longint      zr;
        longint      zi;
        longint      rr;
        longint      ii;
        longint      nr;
        longint      ni;
        int unsigned n;
        zr = start_coord(col, IMAGE_WIDTH);
        zi = start_coord(row, IMAGE_HEIGHT);
        n = 0;
        while (n < iter_max) begin
            // arithmetic shift of the exact product floors it
            rr = (zr * zr) >>> FB;
            ii = (zi * zi) >>> FB;
            if (rr + ii >= ESCAPE_SQ)
                break;
            nr = clip_q(rr - ii + longint'(seed_re));
            ni = clip_q(((zr * zi) >>> (FB - 1)) + longint'(seed_im));
            zr = nr;
            zi = ni;
            n++;
        end
        return n[jet_pkg::COUNT_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_count_t want;
        pixel_count_t got;
        if (!rst_n)
        begin
            seed_re    <= '0;
            seed_im    <= '0;
            iter_max   <= jet_pkg::LIMIT_RESET;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
            count_q.delete();
        end
        else
        begin
            // register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    jet_pkg::CFG_SEED_REAL:  seed_re  <= cfg_data;
                    jet_pkg::CFG_SEED_IMAG:  seed_im  <= cfg_data;
                    jet_pkg::CFG_ITER_LIMIT: iter_max <= cfg_data[jet_pkg::COUNT_BITS-1:0];
                    default: ;
                endcase
            end

            // input transfer: predict its count
            if (in_valid && !in_stall)
            begin
                want.col   = pixel_col;
                want.row   = pixel_row;
                want.count = escape_count(pixel_col, pixel_row);
                count_q.push_back(want);
            end

            // output transfer: compare with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (count_q.size() == 0)
                begin
                    $error("iteration_count: result %0d with no pixel outstanding",
                           iteration_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    got = count_q.pop_front();
                    checked <= checked + 1;
                    if (iteration_count !== got.count)
                    begin
                        $error("iteration_count (col %0d row %0d): expected %0d, actual %0d",
                               got.col, got.row, got.count, iteration_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            pending <= count_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

    import jet_pkg::*;

    localparam int MAX_CYCLES       = 5_000_000;
    localparam int DRAIN_CYCLES     = 600;
    localparam int RANDOM_PHASES    = 12;
    localparam int PIXELS_PER_PHASE = 157;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [INDEX_BITS-1:0] pixel_col    = '0;
    logic [INDEX_BITS-1:0] pixel_row    = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [COUNT_BITS-1:0] iteration_count;
    logic                  cfg_write_en = 1'b0;
    logic [1:0]            cfg_index    = '0;
    logic [CFG_BITS-1:0]   cfg_data     = '0;

    int fail_count;
    int pending;
    int checked;
    int sent          = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    julia_escape_time_pixel dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    escape_time_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .iteration_count (iteration_count),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("[julia_escape_time_pixel] ERROR");
            $finish;
        end
    end

    // 0 none, 1 sender idle, 2 receiver stall, 3 both a little
    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
        endcase
    endtask

    // one pixel transfer, with a random gap ahead of it
    task automatic send_pixel(logic [INDEX_BITS-1:0] col, logic [INDEX_BITS-1:0] row);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // stop sending and wait for every outstanding count
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic configure(logic [31:0] re, logic [31:0] im, logic [7:0] limit);
        drain_results();
        write_reg(CFG_SEED_REAL, re);
        write_reg(CFG_SEED_IMAG, im);
        write_reg(CFG_ITER_LIMIT, {24'd0, limit});
    endtask

    // well-known connected Julia seeds, {re, im} in Q4.28
    function automatic logic [63:0] classic_seed(int k);
        case (k)
            0: return {-32'sd214748365, 32'sd41875931};
            1: return {32'sd76504105, 32'sd2684355};
            2: return {-32'sd107374182, 32'sd161061274};
            default: return {-32'sd195125733, 32'sd50707458};
        endcase
    endfunction

    initial
    begin : stimulus
        logic [63:0]           seed;
        logic [7:0]            limit;
        logic [INDEX_BITS-1:0] col;
        logic [INDEX_BITS-1:0] row;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners, edges, center and alternating bits
        set_idling(0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd2047, 12'd2047);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd1024, 12'd3071);
        send_pixel(12'd4095, 12'd2048);
        send_pixel(12'd2048, 12'd0);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);

        // extreme seeds drive z into saturation
        configure(32'h7FFF_FFFF, 32'h8000_0000, 8'd255);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd3000, 12'd1000);

        // opposite extremes with a single iteration
        configure(32'h8000_0000, 32'h7FFF_FFFF, 8'd1);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd0);

        // limit of zero gives a count of zero
        seed = classic_seed(0);
        configure(seed[63:32], seed[31:0], 8'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1500, 12'd2600);

        // random pixels under several seeds, limits and idling patterns
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 3)
                0: seed = classic_seed($urandom_range(3));
                1: seed = {32'($urandom_range(32'h4000_0000) - 32'h2000_0000),
                           32'($urandom_range(32'h4000_0000) - 32'h2000_0000)};
                default: seed = {$urandom, $urandom};
            endcase
            if (p == 7)
                limit = 8'd255;
            else if (p == 3)
                limit = 8'd1;
            else
                limit = 8'($urandom_range(2, 48));
            configure(seed[63:32], seed[31:0], limit);
            set_idling(p % 4);

            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                // mostly anywhere, some within [-1, 1] on both axes where orbits run long
                if ($urandom_range(99) < 70)
                begin
                    col = 12'($urandom_range(4095));
                    row = 12'($urandom_range(4095));
                end
                else
                begin
                    col = 12'($urandom_range(1024, 3071));
                    row = 12'($urandom_range(1024, 3071));
                end
                if (p == 2 && i == PIXELS_PER_PHASE / 2)
                    drain_results();
                send_pixel(col, row);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pixels sent, %0d counts compared, over %0d seed/limit settings",
                 sent, checked, RANDOM_PHASES + 4);
        $display("seeds: reset, extremes, classic, small and full range; limits 0, 1, 255");
        if (fail_count == 0 && pending == 0)
            $display("[julia_escape_time_pixel] OK");
        else
            $display("[julia_escape_time_pixel] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/jet_pkg.sv
src/jet_front.sv
src/jet_queue.sv
src/jet_engine.sv
src/julia_escape_time_pixel.sv
bench/escape_time_checker.sv
bench/tb_top.sv
